// ===== rtl/assert_macros.svh =====
// assertion macros shared by the septet split rank design
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SSR_ASSERT_IMPLIES(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("%m: check failed");

// next-cycle implication, disabled while reset is high
`define SSR_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("%m: check failed");

`endif

// ===== rtl/ssr_pkg.sv =====
// types, constants and the binomial table of the septet split rank unit
// no dependencies; used by every other file of the design but assert_macros.svh
package ssr_pkg;

   localparam int LABEL_W    = 7;
   localparam int WEIGHT_W   = 30;
   localparam int RANK_W     = 35;
   localparam int AHEAD_W    = 3;
   localparam int POS_W      = 3;
   localparam int PATTERN_W  = 6;
   localparam int ROW_W      = 6;
   localparam int BINOM_ROWS = 64;
   localparam int BINOM_COLS = 8;
   localparam int LEFT_N     = 3;
   localparam int RIGHT_N    = 4;
   localparam int LANE_N     = LEFT_N + RIGHT_N;

   localparam logic [POS_W-1:0]     SUBSET_K      = 3'd7;
   localparam logic [PATTERN_W-1:0] PATTERN_NONE  = 6'd0;
   localparam logic [PATTERN_W-1:0] PATTERN_TOP   = 6'd34;
   localparam logic [PATTERN_W-1:0] PATTERN_CAP   = 6'd33;

   typedef logic [LABEL_W-1:0]   label_type;
   typedef logic [WEIGHT_W-1:0]  weight_type;
   typedef logic [AHEAD_W-1:0]   ahead_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [PATTERN_W-1:0] pattern_type;
   typedef logic [RANK_W-1:0]    rank_type;

   typedef label_type [RIGHT_N-1:0] label_quad_type;
   typedef label_type [LEFT_N-1:0]  label_trio_type;

   typedef weight_type [BINOM_ROWS-1:0][BINOM_COLS-1:0] binom_table_type;

   // one lane's finding: its binomial weight and how many peers sort ahead of it
   typedef struct packed {
      weight_type weight;
      ahead_type  ahead;
   } lane_result_type;

   // everything the merging stage needs from the lane stage
   typedef struct packed {
      weight_type [LANE_N-1:0] weights;
      ahead_type  [LEFT_N-1:0] left_ahead;
      logic                    below_all;
      logic                    above_all;
   } lane_bundle_type;

   typedef struct packed {
      weight_type  subset_sum;
      pattern_type pattern;
   } merge_result_type;

   // pascal triangle, C(n,k) for n < 64 and k < 8
   function automatic binom_table_type build_binom();
      binom_table_type t;
      t = '0;
      for (int n = 0; n < BINOM_ROWS; n++) begin
         t[n][0] = weight_type'(1);
         for (int k = 1; k < BINOM_COLS; k++) begin
            if (n > 0) begin
               t[n][k] = t[n-1][k-1] + t[n-1][k];
            end
         end
      end
      return t;
   endfunction

   localparam binom_table_type BINOM = build_binom();

endpackage

// ===== rtl/ssr_req_if.sv =====
// request channel of the septet split rank unit: one split per transaction
// depends on ssr_pkg
interface ssr_req_if;
   logic                valid;
   logic                ready;
   ssr_pkg::label_type  left_first;
   ssr_pkg::label_type  left_second;
   ssr_pkg::label_type  left_third;
   ssr_pkg::label_type  right_first;
   ssr_pkg::label_type  right_second;
   ssr_pkg::label_type  right_third;
   ssr_pkg::label_type  right_fourth;

   modport source (
      output valid, left_first, left_second, left_third,
      output right_first, right_second, right_third, right_fourth,
      input  ready
   );
   modport sink (
      input  valid, left_first, left_second, left_third,
      input  right_first, right_second, right_third, right_fourth,
      output ready
   );
endinterface

// ===== rtl/ssr_rsp_if.sv =====
// response channel of the septet split rank unit: one rank per transaction
// depends on ssr_pkg
interface ssr_rsp_if;
   logic              valid;
   logic              ready;
   ssr_pkg::rank_type split_rank;

   modport source (output valid, split_rank, input ready);
   modport sink (input valid, split_rank, output ready);
endinterface

// ===== rtl/ssr_sort4.sv =====
// clamps four labels to the taxa count and sorts them into descending order
// depends on ssr_pkg
module ssr_sort4 #(
   parameter int TAXA_COUNT = 64
) (
   input  ssr_pkg::label_quad_type labels_raw,
   output ssr_pkg::label_quad_type labels_sorted
);

   localparam ssr_pkg::label_type TAXA_LIMIT = ssr_pkg::label_type'(TAXA_COUNT);

   ssr_pkg::label_quad_type clamped;
   ssr_pkg::label_quad_type layer_a;
   ssr_pkg::label_quad_type layer_b;

   always_comb begin
      for (int i = 0; i < ssr_pkg::RIGHT_N; i++) begin
         clamped[i] = (labels_raw[i] > TAXA_LIMIT) ? TAXA_LIMIT : labels_raw[i];
      end

      // larger value goes to the lower index at every exchange
      layer_a = clamped;
      if (clamped[0] < clamped[1]) begin
         layer_a[0] = clamped[1];
         layer_a[1] = clamped[0];
      end
      if (clamped[2] < clamped[3]) begin
         layer_a[2] = clamped[3];
         layer_a[3] = clamped[2];
      end

      layer_b = layer_a;
      if (layer_a[0] < layer_a[2]) begin
         layer_b[0] = layer_a[2];
         layer_b[2] = layer_a[0];
      end
      if (layer_a[1] < layer_a[3]) begin
         layer_b[1] = layer_a[3];
         layer_b[3] = layer_a[1];
      end

      labels_sorted = layer_b;
      if (layer_b[1] < layer_b[2]) begin
         labels_sorted[1] = layer_b[2];
         labels_sorted[2] = layer_b[1];
      end
   end

endmodule

// ===== rtl/ssr_lane.sv =====
// one lane: places a label in the merged order and looks up its binomial weight
// depends on ssr_pkg
module ssr_lane (
   input  ssr_pkg::label_type       label,
   input  ssr_pkg::pos_type         base_pos,
   input  ssr_pkg::label_quad_type  peers,
   input  logic [3:0]               peer_en,
   input  logic                     ties_ahead,
   output ssr_pkg::lane_result_type result
);

   ssr_pkg::ahead_type ahead;
   ssr_pkg::pos_type   pos;
   ssr_pkg::pos_type   k;
   logic [ssr_pkg::ROW_W-1:0] row;

   always_comb begin
      ahead = '0;
      for (int j = 0; j < ssr_pkg::RIGHT_N; j++) begin
         if (peer_en[j] && ((peers[j] > label) || (ties_ahead && (peers[j] == label)))) begin
            ahead = ahead + ssr_pkg::ahead_type'(1);
         end
      end
      pos = base_pos + ahead;
      k   = ssr_pkg::SUBSET_K - pos;
      row = ssr_pkg::ROW_W'(label - ssr_pkg::label_type'(1));

      result.ahead  = ahead;
      // label zero carries no weight
      result.weight = (label == '0) ? '0 : ssr_pkg::BINOM[row][k];
   end

endmodule

// ===== rtl/ssr_merge.sv =====
// merging stage: sums the lane weights and forms the split pattern number
// depends on ssr_pkg
module ssr_merge (
   input  ssr_pkg::lane_bundle_type  bundle,
   output ssr_pkg::merge_result_type result
);

   localparam ssr_pkg::pos_type K_FIRST  = 3'd3;
   localparam ssr_pkg::pos_type K_SECOND = 3'd2;
   localparam ssr_pkg::pos_type K_THIRD  = 3'd1;

   logic [ssr_pkg::ROW_W-1:0] row_a;
   logic [ssr_pkg::ROW_W-1:0] row_b;
   logic [ssr_pkg::ROW_W-1:0] row_c;
   ssr_pkg::weight_type       pat_sum;
   ssr_pkg::pattern_type      pat_raw;
   ssr_pkg::weight_type       acc;

   always_comb begin
      acc = '0;
      for (int i = 0; i < ssr_pkg::LANE_N; i++) begin
         acc = acc + bundle.weights[i];
      end

      // colex position minus one of each left label: right labels at or below it plus slot
      row_a = ssr_pkg::ROW_W'(3'd6 - bundle.left_ahead[0]);
      row_b = ssr_pkg::ROW_W'(3'd5 - bundle.left_ahead[1]);
      row_c = ssr_pkg::ROW_W'(3'd4 - bundle.left_ahead[2]);
      pat_sum = ssr_pkg::BINOM[row_a][K_FIRST] + ssr_pkg::BINOM[row_b][K_SECOND]
              + ssr_pkg::BINOM[row_c][K_THIRD];
      pat_raw = pat_sum[ssr_pkg::PATTERN_W-1:0];

      result.subset_sum = acc;
      if (bundle.below_all) begin
         result.pattern = ssr_pkg::PATTERN_NONE;
      end else if (bundle.above_all) begin
         result.pattern = ssr_pkg::PATTERN_TOP;
      end else if (pat_raw > ssr_pkg::PATTERN_CAP) begin
         // tie across sides keeps the split off the top pattern
         result.pattern = ssr_pkg::PATTERN_CAP;
      end else begin
         result.pattern = pat_raw;
      end
   end

endmodule

// ===== rtl/septet_split_rank_unit.sv =====
// top level of the septet split rank unit: sort, lanes, merge and scale pipeline
// depends on ssr_pkg, ssr_req_if, ssr_rsp_if, ssr_sort4, ssr_lane, ssr_merge, assert_macros.svh
//
//   channel   direction  payload                                   bits
//   req_ch    in         left_first..third, right_first..fourth    7 x 7
//   rsp_ch    out        split_rank                                35
//
// one transaction per cycle sustained while rsp_ch.ready stays high; the stages are
//   sort, lanes, merge and scale, each ended by a register
// reset clears the stage valid bits only
// a stalled response holds the last stage; earlier stages keep filling
//   until every stage is occupied, and only then is req_ch.ready low
`include "assert_macros.svh"

module septet_split_rank_unit #(
   parameter int TAXA_COUNT = 64
) (
   input logic        clock,
   input logic        reset,
   ssr_req_if.sink    req_ch,
   ssr_rsp_if.source  rsp_ch
);

   // stage valid bits and per-stage ready
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   ssr_pkg::label_quad_type   left_raw, right_raw;
   ssr_pkg::label_quad_type   left_sorted, right_sorted;
   ssr_pkg::label_trio_type   left_ff;
   ssr_pkg::label_quad_type   right_ff;
   ssr_pkg::label_quad_type   left_peers;
   ssr_pkg::lane_result_type  lane_res [ssr_pkg::LANE_N];
   ssr_pkg::lane_bundle_type  bundle_in, bundle_ff;
   ssr_pkg::merge_result_type merge_in, merge_ff;
   ssr_pkg::rank_type         rank_in, rank_ff;
   ssr_pkg::rank_type         sum_wide;

   assign rdy4 = !v4_ff || rsp_ch.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   always_comb begin
      v1_in = rdy1 ? req_ch.valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: clamp and sort each side; the left side pads with a zero that sorts last
   assign left_raw  = {ssr_pkg::label_type'(0), req_ch.left_third,
                       req_ch.left_second, req_ch.left_first};
   assign right_raw = {req_ch.right_fourth, req_ch.right_third,
                       req_ch.right_second, req_ch.right_first};

   ssr_sort4 #(.TAXA_COUNT(TAXA_COUNT)) u_sort_left (
      .labels_raw    (left_raw),
      .labels_sorted (left_sorted)
   );

   ssr_sort4 #(.TAXA_COUNT(TAXA_COUNT)) u_sort_right (
      .labels_raw    (right_raw),
      .labels_sorted (right_sorted)
   );

   always_ff @(posedge clock) begin
      if (rdy1 && req_ch.valid) begin
         left_ff  <= left_sorted[ssr_pkg::LEFT_N-1:0];
         right_ff <= right_sorted;
      end
   end

   // stage 2: seven lanes, left labels win ties against right labels
   assign left_peers = {ssr_pkg::label_type'(0), left_ff};

   for (genvar j = 0; j < ssr_pkg::LEFT_N; j++) begin : g_left_lane
      ssr_lane u_lane (
         .label      (left_ff[j]),
         .base_pos   (ssr_pkg::pos_type'(j)),
         .peers      (right_ff),
         .peer_en    (4'b1111),
         .ties_ahead (1'b0),
         .result     (lane_res[j])
      );
   end

   for (genvar m = 0; m < ssr_pkg::RIGHT_N; m++) begin : g_right_lane
      ssr_lane u_lane (
         .label      (right_ff[m]),
         .base_pos   (ssr_pkg::pos_type'(m)),
         .peers      (left_peers),
         .peer_en    (4'b0111),
         .ties_ahead (1'b1),
         .result     (lane_res[ssr_pkg::LEFT_N + m])
      );
   end

   always_comb begin
      for (int i = 0; i < ssr_pkg::LANE_N; i++) begin
         bundle_in.weights[i] = lane_res[i].weight;
      end
      for (int j = 0; j < ssr_pkg::LEFT_N; j++) begin
         bundle_in.left_ahead[j] = lane_res[j].ahead;
      end
      bundle_in.below_all = left_ff[0] < right_ff[ssr_pkg::RIGHT_N-1];
      bundle_in.above_all = left_ff[ssr_pkg::LEFT_N-1] > right_ff[0];
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         bundle_ff <= bundle_in;
      end
   end

   // stage 3: merge lane results
   ssr_merge u_merge (
      .bundle (bundle_ff),
      .result (merge_in)
   );

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         merge_ff <= merge_in;
      end
   end

   // stage 4: times 35 as 32 + 2 + 1, plus the pattern
   always_comb begin
      sum_wide = ssr_pkg::RANK_W'(merge_ff.subset_sum);
      rank_in  = (sum_wide << 5) + (sum_wide << 1) + sum_wide
               + ssr_pkg::RANK_W'(merge_ff.pattern);
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         rank_ff <= rank_in;
      end
   end

   assign rsp_ch.valid      = v4_ff;
   assign rsp_ch.split_rank = rank_ff;

   `SSR_ASSERT_IMPLIES(a_blocked_only_when_full, clock, reset, !req_ch.ready, v1_ff && v2_ff && v3_ff && v4_ff)
   `SSR_ASSERT_IMPLIES(a_pattern_in_range, clock, reset, v3_ff, merge_ff.pattern <= ssr_pkg::PATTERN_TOP)
   `SSR_ASSERT_IMPLIES(a_left_below_all, clock, reset, v2_ff && bundle_ff.below_all, bundle_ff.left_ahead[0] == 3'd4 && bundle_ff.left_ahead[2] == 3'd4)
   `SSR_ASSERT_IMPLIES(a_left_above_all, clock, reset, v2_ff && bundle_ff.above_all, bundle_ff.left_ahead[0] == 3'd0 && bundle_ff.left_ahead[2] == 3'd0)
   `SSR_ASSERT_NEXT(a_merge_held_on_stall, clock, reset, v4_ff && !rsp_ch.ready && v3_ff, v3_ff && v4_ff)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of septet_split_rank_unit: directed splits, then random ones
// depends on ssr_pkg, ssr_req_if, ssr_rsp_if and the unit; ranks checked against fixed values or a local predictor
module tb_top;

   localparam int TAXA_COUNT          = 64;
   localparam int PATTERNS_PER_SUBSET = 35;
   localparam int RANDOM_SPLITS       = 1600;
   localparam int LONG_HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES        = 16;

   typedef struct packed {
      ssr_pkg::label_type left_first;
      ssr_pkg::label_type left_second;
      ssr_pkg::label_type left_third;
      ssr_pkg::label_type right_first;
      ssr_pkg::label_type right_second;
      ssr_pkg::label_type right_third;
      ssr_pkg::label_type right_fourth;
   } split_type;

   typedef struct {
      split_type         split;
      bit                known;
      ssr_pkg::rank_type rank;
   } split_row_type;

   typedef int label_list[$];

   logic clock;
   logic reset;

   ssr_req_if req_ch ();
   ssr_rsp_if rsp_ch ();

   septet_split_rank_unit #(
      .TAXA_COUNT(TAXA_COUNT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ssr_pkg::rank_type expected_ranks[$];
   int                rank_errors = 0;
   int                ranks_seen  = 0;
   bit                long_hold   = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned binomial(longint unsigned n, longint unsigned k);
      longint unsigned r;
      r = 1;
      if (n < k) begin
         return 0;
      end
      for (longint unsigned i = 0; i < k; i++) begin
         r = r * (n - i) / (i + 1);
      end
      return r;
   endfunction

   function automatic int saturate_label(ssr_pkg::label_type x);
      return (int'(x) > TAXA_COUNT) ? TAXA_COUNT : int'(x);
   endfunction

   function automatic label_list sort_down(label_list v);
      int t;
      int j;
      for (int i = 1; i < v.size(); i++) begin
         t = v[i];
         j = i - 1;
         while (j >= 0 && v[j] < t) begin
            v[j+1] = v[j];
            j--;
         end
         v[j+1] = t;
      end
      return v;
   endfunction

   function automatic int count_at_or_below(label_list v, int x);
      int c;
      c = 0;
      foreach (v[i]) begin
         if (v[i] <= x) begin
            c++;
         end
      end
      return c;
   endfunction

   function automatic ssr_pkg::rank_type predict_split_rank(split_type s);
      label_list       lefts;
      label_list       rights;
      label_list       merged;
      longint unsigned subset_sum;
      longint unsigned pattern;
      int              a;
      int              b;
      int              c;
      lefts  = sort_down({saturate_label(s.left_first), saturate_label(s.left_second),
                          saturate_label(s.left_third)});
      rights = sort_down({saturate_label(s.right_first), saturate_label(s.right_second),
                          saturate_label(s.right_third), saturate_label(s.right_fourth)});
      merged = sort_down({lefts, rights});
      subset_sum = 0;
      for (int i = 0; i < ssr_pkg::LANE_N; i++) begin
         if (merged[i] != 0) begin
            subset_sum += binomial(merged[i] - 1, ssr_pkg::LANE_N - i);
         end
      end
      if (lefts[0] < rights[ssr_pkg::RIGHT_N-1]) begin
         pattern = ssr_pkg::PATTERN_NONE;
      end else if (lefts[ssr_pkg::LEFT_N-1] > rights[0]) begin
         pattern = ssr_pkg::PATTERN_TOP;
      end else begin
         // left wins ties when placing positions; the top pattern needs strict order
         a = count_at_or_below(rights, lefts[0]) + 3;
         b = count_at_or_below(rights, lefts[1]) + 2;
         c = count_at_or_below(rights, lefts[2]) + 1;
         pattern = binomial(a - 1, 3) + binomial(b - 1, 2) + binomial(c - 1, 1);
         if (pattern > ssr_pkg::PATTERN_CAP) begin
            pattern = ssr_pkg::PATTERN_CAP;
         end
      end
      return ssr_pkg::rank_type'(PATTERNS_PER_SUBSET * subset_sum + pattern);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic split_row_type directed_split(int lf, int ls, int lt, int rf, int rs,
                                                    int rt, int rr, bit known,
                                                    ssr_pkg::rank_type rank);
      split_row_type row;
      row.split = '{ssr_pkg::label_type'(lf), ssr_pkg::label_type'(ls),
                    ssr_pkg::label_type'(lt), ssr_pkg::label_type'(rf),
                    ssr_pkg::label_type'(rs), ssr_pkg::label_type'(rt),
                    ssr_pkg::label_type'(rr)};
      row.known = known;
      row.rank  = rank;
      return row;
   endfunction

   function automatic split_type random_split();
      int         picks[ssr_pkg::LANE_N];
      bit [127:0] taken;
      int         roll;
      int         top;
      int         v;
      taken = '0;
      roll  = $urandom_range(0, 99);
      top   = ($urandom_range(0, 3) == 0) ? 12 : TAXA_COUNT;
      for (int i = 0; i < ssr_pkg::LANE_N; i++) begin
         if (roll < 85) begin
            // distinct labels in range, random side assignment
            do begin
               v = $urandom_range(1, top);
            end while (taken[v]);
            taken[v] = 1'b1;
         end else if (roll < 93) begin
            v = $urandom_range(0, 127);
         end else begin
            v = $urandom_range(0, 8);
         end
         picks[i] = v;
      end
      return '{ssr_pkg::label_type'(picks[0]), ssr_pkg::label_type'(picks[1]),
               ssr_pkg::label_type'(picks[2]), ssr_pkg::label_type'(picks[3]),
               ssr_pkg::label_type'(picks[4]), ssr_pkg::label_type'(picks[5]),
               ssr_pkg::label_type'(picks[6])};
   endfunction

   // hold the split on the channel until the unit takes it
   task automatic offer_split(split_type s, ssr_pkg::rank_type want);
      req_ch.valid        <= 1'b1;
      req_ch.left_first   <= s.left_first;
      req_ch.left_second  <= s.left_second;
      req_ch.left_third   <= s.left_third;
      req_ch.right_first  <= s.right_first;
      req_ch.right_second <= s.right_second;
      req_ch.right_third  <= s.right_third;
      req_ch.right_fourth <= s.right_fourth;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      expected_ranks.push_back(want);
   endtask

   // always waits on the clock before checking, so the next drive lands in a later step
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_ranks.size() != 0);
   endtask

   // ---------------------------------------------------------------- clock, reset, limit

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

   // ---------------------------------------------------------------- sender

   initial begin : sender
      split_row_type directed[$];
      split_type     s;
      int            burst_left;
      int            gap;

      req_ch.valid        <= 1'b0;
      req_ch.left_first   <= '0;
      req_ch.left_second  <= '0;
      req_ch.left_third   <= '0;
      req_ch.right_first  <= '0;
      req_ch.right_second <= '0;
      req_ch.right_third  <= '0;
      req_ch.right_fourth <= '0;

      directed.push_back(directed_split(1, 2, 3, 4, 5, 6, 7, 1'b1, 35'd0));
      directed.push_back(directed_split(7, 6, 5, 4, 3, 2, 1, 1'b1, 35'd34));
      directed.push_back(directed_split(64, 63, 62, 61, 60, 59, 58, 1'b1, 35'd21742566719));
      directed.push_back(directed_split(58, 59, 60, 61, 62, 63, 64, 1'b1, 35'd21742566685));
      // all zero: every pair ties, top pattern is capped
      directed.push_back(directed_split(0, 0, 0, 0, 0, 0, 0, 1'b1, 35'd33));
      directed.push_back(directed_split(127, 127, 127, 127, 127, 127, 127, 1'b0, '0));
      directed.push_back(directed_split(65, 100, 127, 1, 2, 3, 4, 1'b0, '0));
      directed.push_back(directed_split(0, 0, 1, 2, 3, 4, 5, 1'b0, '0));
      directed.push_back(directed_split(5, 6, 7, 5, 1, 2, 3, 1'b0, '0));
      directed.push_back(directed_split(5, 5, 5, 5, 5, 5, 5, 1'b0, '0));
      directed.push_back(directed_split(9, 9, 2, 3, 9, 1, 4, 1'b0, '0));
      directed.push_back(directed_split(85, 42, 127, 42, 85, 1, 64, 1'b0, '0));
      directed.push_back(directed_split(10, 30, 50, 20, 40, 60, 5, 1'b0, '0));
      directed.push_back(directed_split(2, 4, 6, 1, 3, 5, 7, 1'b0, '0));
      directed.push_back(directed_split(64, 1, 33, 32, 2, 63, 34, 1'b0, '0));
      directed.push_back(directed_split(12, 11, 1, 10, 9, 8, 2, 1'b0, '0));
      directed.push_back(directed_split(3, 64, 7, 6, 5, 4, 8, 1'b0, '0));
      directed.push_back(directed_split(127, 126, 0, 64, 63, 1, 2, 1'b0, '0));

      do begin
         @(posedge clock);
      end while (reset);

      foreach (directed[i]) begin
         offer_split(directed[i].split,
                     directed[i].known ? directed[i].rank : predict_split_rank(directed[i].split));
      end
      wait_for_drain();

      burst_left = 0;
      for (int n = 0; n < RANDOM_SPLITS; n++) begin
         if (n == RANDOM_SPLITS / 2) begin
            wait_for_drain();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
               0:       gap = 0;
               1:       gap = $urandom_range(1, 2);
               2:       gap = $urandom_range(1, 8);
               default: gap = $urandom_range(10, 24);
            endcase
            // keep feeding while the receiver is held off so the pipeline backs up
            if (long_hold) begin
               gap = 0;
            end
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         s = random_split();
         offer_split(s, predict_split_rank(s));
         burst_left--;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rank_errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin : receiver
      int mode;
      int span;
      int period;
      int on_cycles;
      int phase;
      int next_hold_at;

      rsp_ch.ready <= 1'b0;
      next_hold_at = 150;
      phase        = 0;
      forever begin
         mode      = $urandom_range(0, 3);
         span      = $urandom_range(16, 200);
         period    = $urandom_range(2, 7);
         on_cycles = $urandom_range(1, period - 1);
         repeat (span) begin
            @(posedge clock);
            if (ranks_seen >= next_hold_at) begin
               long_hold = 1'b1;
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(posedge clock);
               long_hold = 1'b0;
               next_hold_at += 700;
            end
            phase = (phase + 1) % period;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (phase < on_cycles);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin : rank_check
      ssr_pkg::rank_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         ranks_seen++;
         if (expected_ranks.size() == 0) begin
            $display("%0t: split_rank with no transaction pending: expected none, actual %0d",
                     $time, rsp_ch.split_rank);
            rank_errors++;
         end else begin
            want = expected_ranks.pop_front();
            if (rsp_ch.split_rank !== want) begin
               $display("%0t: split_rank mismatch: expected %0d, actual %0d",
                        $time, want, rsp_ch.split_rank);
               rank_errors++;
            end
         end
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssr_pkg.sv
rtl/ssr_req_if.sv
rtl/ssr_rsp_if.sv
rtl/ssr_sort4.sv
rtl/ssr_lane.sv
rtl/ssr_merge.sv
rtl/septet_split_rank_unit.sv
tb/sv/tb_top.sv
